### hdl/cba_pkg.sv
// Package for the contiguous block allocator: sizes, codes, controller states
// and the command and status structs between controller and datapath.
// Depends on nothing.
package cba_pkg;

  localparam int NUM_BLOCKS = 128;
  localparam int BLOCK_KB   = 8;
  localparam int MAX_PROCS  = 16;

  localparam int KIND_W     = 1;
  localparam int PROC_NUM_W = 4;
  localparam int KB_W       = 11;
  localparam int STATUS_W   = 2;
  localparam int FIRST_W    = 7;
  localparam int USE_W      = 8;

  localparam int BLK_W    = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W    = $clog2(NUM_BLOCKS + 1);
  localparam int PROC_W   = $clog2(MAX_PROCS);
  localparam int LIMIT_KB = NUM_BLOCKS * BLOCK_KB;
  localparam int LIM_W    = $clog2(LIMIT_KB + 1);
  localparam int ACC_W    = (LIM_W > KB_W) ? LIM_W : KB_W;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BUSY      = 2'd3
  } status_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_MARK,
    S_FREE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    clr_step;
    logic    load_req;
    logic    start_scan;
    logic    scan_step;
    logic    start_mark;
    logic    start_free;
    logic    run_step;
    logic    run_fill;
    logic    commit_alloc;
    logic    commit_free;
    logic    load_rsp;
    status_t rsp_status;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic proc_oob;
    logic slot_valid;
    logic size_bad;
    logic scan_found;
    logic scan_end;
    logic run_last;
  } sts_t;

endpackage

### hdl/cba_if.sv
// Handshake interfaces for the allocator request and response channels.
// Depends on cba_pkg for the field widths.
interface cba_req_if;
  import cba_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     kind;
  logic [PROC_NUM_W-1:0] process_num;
  logic [KB_W-1:0]       segment_kb;

  modport source (output valid, output kind, output process_num, output segment_kb,
                  input ready);
  modport sink (input valid, input kind, input process_num, input segment_kb,
                output ready);
endinterface

interface cba_rsp_if;
  import cba_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FIRST_W-1:0]  first_block;
  logic [USE_W-1:0]    blocks_in_use;

  modport source (output valid, output status, output first_block, output blocks_in_use,
                  input ready);
  modport sink (input valid, input status, input first_block, input blocks_in_use,
                output ready);
endinterface

### hdl/cba_ctl.sv
// Controller of the contiguous block allocator: sequences the clearing pass,
// the lookup, the bitmap scan and the run update. Depends on cba_pkg.
module cba_ctl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output cba_pkg::cmd_t cmd,
  input  cba_pkg::sts_t sts
);
  import cba_pkg::*;

  state_t  state;
  state_t  state_next;
  status_t code;
  status_t code_next;
  logic    out_valid;
  logic    slot_free;

  assign slot_free = !out_valid || rsp_ready;
  assign rsp_valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      code      <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      code  <= code_next;
      if (cmd.load_rsp) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    code_next  = code;
    unique case (state)
      S_CLEAR: begin
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        priority if (sts.proc_oob) begin
          code_next  = ST_NOT_FOUND;
          state_next = S_DONE;
        end else if (sts.is_free && !sts.slot_valid) begin
          code_next  = ST_NOT_FOUND;
          state_next = S_DONE;
        end else if (sts.is_free) begin
          state_next = S_FREE;
        end else if (sts.slot_valid) begin
          code_next  = ST_BUSY;
          state_next = S_DONE;
        end else if (sts.size_bad) begin
          code_next  = ST_NO_SPACE;
          state_next = S_DONE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (sts.scan_found) begin
          state_next = S_MARK;
        end else if (sts.scan_end) begin
          code_next  = ST_NO_SPACE;
          state_next = S_DONE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_MARK, S_FREE: begin
        if (sts.run_last) begin
          code_next  = ST_OK;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.rsp_status = code;
    req_ready      = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      S_IDLE: begin
        req_ready    = 1'b1;
        cmd.load_req = req_valid;
      end
      S_LOOK: begin
        cmd.start_free = !sts.proc_oob && sts.is_free && sts.slot_valid;
        cmd.start_scan = !sts.proc_oob && !sts.is_free && !sts.slot_valid && !sts.size_bad;
      end
      S_SCAN: begin
        cmd.scan_step  = 1'b1;
        cmd.start_mark = sts.scan_found;
      end
      S_MARK: begin
        cmd.run_step     = 1'b1;
        cmd.run_fill     = 1'b1;
        cmd.commit_alloc = sts.run_last;
      end
      S_FREE: begin
        cmd.run_step    = 1'b1;
        cmd.run_fill    = 1'b0;
        cmd.commit_free = sts.run_last;
      end
      S_DONE: begin
        cmd.load_rsp = slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### hdl/cba_dp.sv
// Datapath of the contiguous block allocator: block bitmap memory, run tables,
// scan counters, occupancy count and response registers. Depends on cba_pkg.
module cba_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  cba_pkg::cmd_t                  cmd,
  output cba_pkg::sts_t                  sts,
  input  logic [cba_pkg::KIND_W-1:0]     kind,
  input  logic [cba_pkg::PROC_NUM_W-1:0] process_num,
  input  logic [cba_pkg::KB_W-1:0]       segment_kb,
  output logic [cba_pkg::STATUS_W-1:0]   status,
  output logic [cba_pkg::FIRST_W-1:0]    first_block,
  output logic [cba_pkg::USE_W-1:0]      blocks_in_use
);
  import cba_pkg::*;

  logic                  used_mem [NUM_BLOCKS];
  logic [BLK_W-1:0]      start_mem [MAX_PROCS];
  logic [CNT_W-1:0]      len_mem [MAX_PROCS];
  logic [MAX_PROCS-1:0]  run_valid;

  kind_t                 kind_q;
  logic [PROC_NUM_W-1:0] proc_q;
  logic [KB_W-1:0]       kb_q;
  logic [BLK_W-1:0]      tab_start_q;
  logic [CNT_W-1:0]      tab_len_q;

  logic [CNT_W-1:0]      idx;
  logic [CNT_W-1:0]      eval_idx;
  logic                  eval_v;
  logic                  rd_q;
  logic [CNT_W-1:0]      run;
  logic [ACC_W-1:0]      acc;
  logic [CNT_W-1:0]      run_nx;
  logic [ACC_W-1:0]      acc_inc;
  logic [ACC_W-1:0]      acc_nx;

  logic [BLK_W-1:0]      cursor;
  logic [CNT_W-1:0]      remain;
  logic [BLK_W-1:0]      base;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      occ;

  logic                  mem_we;
  logic [BLK_W-1:0]      mem_wa;
  logic                  mem_wd;
  logic [PROC_W-1:0]     slot_in;
  logic [PROC_W-1:0]     slot_q;

  assign slot_in = PROC_W'(process_num);
  assign slot_q  = PROC_W'(proc_q);

  assign acc_inc = acc + ACC_W'(BLOCK_KB);
  assign run_nx  = rd_q ? '0 : run + CNT_W'(1);
  assign acc_nx  = rd_q ? '0 : acc_inc;

  always_comb begin
    sts            = '0;
    sts.clr_last   = (idx == CNT_W'(NUM_BLOCKS - 1));
    sts.is_free    = (kind_q == KIND_FREE);
    sts.proc_oob   = (int'(proc_q) >= MAX_PROCS);
    sts.slot_valid = run_valid[slot_q];
    sts.size_bad   = (kb_q == '0) || (ACC_W'(kb_q) > ACC_W'(LIMIT_KB));
    sts.scan_found = eval_v && !rd_q && (acc_inc >= ACC_W'(kb_q));
    sts.scan_end   = eval_v && (eval_idx == CNT_W'(NUM_BLOCKS - 1));
    sts.run_last   = (remain == CNT_W'(1));
  end

  always_comb begin
    mem_we = cmd.clr_step || cmd.run_step;
    mem_wa = cmd.clr_step ? idx[BLK_W-1:0] : cursor;
    mem_wd = cmd.clr_step ? 1'b0 : cmd.run_fill;
  end

  // Block bitmap: one write port, one registered read port at the scan index.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      used_mem[mem_wa] <= mem_wd;
    end
    rd_q <= used_mem[idx[BLK_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_alloc) begin
      start_mem[slot_q] <= base;
      len_mem[slot_q]   <= cnt;
    end
    if (cmd.load_req) begin
      tab_start_q <= start_mem[slot_in];
      tab_len_q   <= len_mem[slot_in];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      kind_q <= kind_t'(kind);
      proc_q <= process_num;
      kb_q   <= segment_kb;
    end
    if (cmd.start_mark) begin
      base   <= BLK_W'(eval_idx + CNT_W'(1) - run_nx);
      cursor <= BLK_W'(eval_idx + CNT_W'(1) - run_nx);
      cnt    <= run_nx;
      remain <= run_nx;
    end else if (cmd.start_free) begin
      base   <= tab_start_q;
      cursor <= tab_start_q;
      cnt    <= tab_len_q;
      remain <= tab_len_q;
    end else if (cmd.run_step) begin
      cursor <= cursor + BLK_W'(1);
      remain <= remain - CNT_W'(1);
    end
    if (cmd.start_scan) begin
      run <= '0;
      acc <= '0;
    end else if (cmd.scan_step && eval_v) begin
      run <= run_nx;
      acc <= acc_nx;
    end
    if (cmd.scan_step) begin
      eval_idx <= idx;
    end
    if (cmd.load_rsp) begin
      status        <= cmd.rsp_status;
      first_block   <= (cmd.rsp_status == ST_OK) ? FIRST_W'(base) : '0;
      blocks_in_use <= USE_W'(occ);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      eval_v    <= 1'b0;
      occ       <= '0;
      run_valid <= '0;
    end else begin
      if (cmd.start_scan) begin
        idx    <= '0;
        eval_v <= 1'b0;
      end else if (cmd.clr_step || cmd.scan_step) begin
        idx    <= idx + CNT_W'(1);
        eval_v <= cmd.scan_step;
      end
      if (cmd.commit_alloc) begin
        run_valid[slot_q] <= 1'b1;
        occ               <= occ + cnt;
      end else if (cmd.commit_free) begin
        run_valid[slot_q] <= 1'b0;
        occ               <= (occ >= cnt) ? occ - cnt : '0;
      end
    end
  end

endmodule

### hdl/contiguous_block_allocator.sv
// First-fit contiguous block allocator, top level: controller and datapath.
// A new item is accepted only after the previous one is done. An allocate is paced by
// the bitmap scan (one block per cycle through the bitmap memory read port) and
// marking (one block per cycle on its write port); a free by clearing its run.
// After reset a clearing pass over all NUM_BLOCKS blocks runs and no item is accepted.
// Depends on cba_pkg, cba_if, cba_ctl and cba_dp.
module contiguous_block_allocator (
  input logic   clk,
  input logic   rst,
  cba_req_if.sink   req,
  cba_rsp_if.source rsp
);
  import cba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cba_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  cba_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .kind          (req.kind),
    .process_num   (req.process_num),
    .segment_kb    (req.segment_kb),
    .status        (rsp.status),
    .first_block   (rsp.first_block),
    .blocks_in_use (rsp.blocks_in_use)
  );

endmodule
